/* design/sis_pkg.sv */
// Shared constants, index names and types for the segment intersection test pipeline.
`default_nettype none
package sis_pkg;

  localparam int unsigned CoordBitsDef = 16;

  // Difference vector slots
  localparam int unsigned NumDiff = 8;
  localparam int unsigned DiD1x = 0;
  localparam int unsigned DiD1y = 1;
  localparam int unsigned DiD2x = 2;
  localparam int unsigned DiD2y = 3;
  localparam int unsigned DiWx  = 4;
  localparam int unsigned DiWy  = 5;
  localparam int unsigned DiEx  = 6;
  localparam int unsigned DiEy  = 7;

  // Product slots
  localparam int unsigned NumProd = 16;
  localparam int unsigned PrD1xD2y = 0;
  localparam int unsigned PrD1yD2x = 1;
  localparam int unsigned PrWxD2y  = 2;
  localparam int unsigned PrWyD2x  = 3;
  localparam int unsigned PrWxD1y  = 4;
  localparam int unsigned PrWyD1x  = 5;
  localparam int unsigned PrD2xD2x = 6;
  localparam int unsigned PrD2yD2y = 7;
  localparam int unsigned PrWxD2x  = 8;
  localparam int unsigned PrWyD2y  = 9;
  localparam int unsigned PrD1xD1x = 10;
  localparam int unsigned PrD1yD1y = 11;
  localparam int unsigned PrWxD1x  = 12;
  localparam int unsigned PrWyD1y  = 13;
  localparam int unsigned PrExD1x  = 14;
  localparam int unsigned PrEyD1y  = 15;

  // Cross and dot product slots
  localparam int unsigned NumSum = 8;
  localparam int unsigned SmD  = 0;  // cross(d1,d2)
  localparam int unsigned SmP  = 1;  // cross(w,d2)
  localparam int unsigned SmQ  = 2;  // cross(w,d1)
  localparam int unsigned SmN2 = 3;  // |d2|^2
  localparam int unsigned SmT  = 4;  // dot(w,d2)
  localparam int unsigned SmN  = 5;  // |d1|^2
  localparam int unsigned SmA  = 6;  // dot(w,d1)
  localparam int unsigned SmB  = 7;  // dot(E2-S1,d1)

  typedef struct packed {
    logic d1_zero;
    logic d2_zero;
    logic w_zero;
  } sis_flags_t;

endpackage
`default_nettype wire

/* design/sis_diff.sv */
// Stage 1: endpoint differences and point flags.
`default_nettype none
module sis_diff import sis_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic signed [CoordBits-1:0] ax1_i,
  input  wire logic signed [CoordBits-1:0] ay1_i,
  input  wire logic signed [CoordBits-1:0] bx1_i,
  input  wire logic signed [CoordBits-1:0] by1_i,
  input  wire logic signed [CoordBits-1:0] ax2_i,
  input  wire logic signed [CoordBits-1:0] ay2_i,
  input  wire logic signed [CoordBits-1:0] bx2_i,
  input  wire logic signed [CoordBits-1:0] by2_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic signed [CoordBits:0]        diff_o [NumDiff],
  output sis_flags_t                       flags_o
);

  localparam int unsigned DW = CoordBits + 1;

  logic                 valid_q;
  logic signed [DW-1:0] diff_d [NumDiff];
  logic signed [DW-1:0] diff_q [NumDiff];
  sis_flags_t           flags_d, flags_q;

  function automatic logic signed [DW-1:0] sub(input logic signed [CoordBits-1:0] a,
                                                input logic signed [CoordBits-1:0] b);
    sub = $signed({a[CoordBits-1], a}) - $signed({b[CoordBits-1], b});
  endfunction

  always_comb begin
    diff_d[DiD1x] = sub(bx1_i, ax1_i);
    diff_d[DiD1y] = sub(by1_i, ay1_i);
    diff_d[DiD2x] = sub(bx2_i, ax2_i);
    diff_d[DiD2y] = sub(by2_i, ay2_i);
    diff_d[DiWx]  = sub(ax2_i, ax1_i);
    diff_d[DiWy]  = sub(ay2_i, ay1_i);
    diff_d[DiEx]  = sub(bx2_i, ax1_i);
    diff_d[DiEy]  = sub(by2_i, ay1_i);
    flags_d.d1_zero = (bx1_i == ax1_i) && (by1_i == ay1_i);
    flags_d.d2_zero = (bx2_i == ax2_i) && (by2_i == ay2_i);
    flags_d.w_zero  = (ax2_i == ax1_i) && (ay2_i == ay1_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      diff_q  <= diff_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

/* design/sis_prod.sv */
// Stage 2: bank of registered products of the difference vectors.
`default_nettype none
module sis_prod import sis_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [CoordBits:0]     diff_i [NumDiff],
  input  wire sis_flags_t                    flags_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [2*CoordBits+1:0]      prod_o [NumProd],
  output sis_flags_t                         flags_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;

  logic                 valid_q;
  logic signed [DW-1:0] opa [NumProd];
  logic signed [DW-1:0] opb [NumProd];
  logic signed [PW-1:0] prod_d [NumProd];
  logic signed [PW-1:0] prod_q [NumProd];
  sis_flags_t           flags_q;

  always_comb begin
    opa[PrD1xD2y] = diff_i[DiD1x]; opb[PrD1xD2y] = diff_i[DiD2y];
    opa[PrD1yD2x] = diff_i[DiD1y]; opb[PrD1yD2x] = diff_i[DiD2x];
    opa[PrWxD2y]  = diff_i[DiWx];  opb[PrWxD2y]  = diff_i[DiD2y];
    opa[PrWyD2x]  = diff_i[DiWy];  opb[PrWyD2x]  = diff_i[DiD2x];
    opa[PrWxD1y]  = diff_i[DiWx];  opb[PrWxD1y]  = diff_i[DiD1y];
    opa[PrWyD1x]  = diff_i[DiWy];  opb[PrWyD1x]  = diff_i[DiD1x];
    opa[PrD2xD2x] = diff_i[DiD2x]; opb[PrD2xD2x] = diff_i[DiD2x];
    opa[PrD2yD2y] = diff_i[DiD2y]; opb[PrD2yD2y] = diff_i[DiD2y];
    opa[PrWxD2x]  = diff_i[DiWx];  opb[PrWxD2x]  = diff_i[DiD2x];
    opa[PrWyD2y]  = diff_i[DiWy];  opb[PrWyD2y]  = diff_i[DiD2y];
    opa[PrD1xD1x] = diff_i[DiD1x]; opb[PrD1xD1x] = diff_i[DiD1x];
    opa[PrD1yD1y] = diff_i[DiD1y]; opb[PrD1yD1y] = diff_i[DiD1y];
    opa[PrWxD1x]  = diff_i[DiWx];  opb[PrWxD1x]  = diff_i[DiD1x];
    opa[PrWyD1y]  = diff_i[DiWy];  opb[PrWyD1y]  = diff_i[DiD1y];
    opa[PrExD1x]  = diff_i[DiEx];  opb[PrExD1x]  = diff_i[DiD1x];
    opa[PrEyD1y]  = diff_i[DiEy];  opb[PrEyD1y]  = diff_i[DiD1y];
  end

  for (genvar g = 0; g < NumProd; g++) begin : g_mul
    assign prod_d[g] = PW'($signed({{DW{opa[g][DW-1]}}, opa[g]}) *
                           $signed({{DW{opb[g][DW-1]}}, opb[g]}));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q  <= prod_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

/* design/sis_sum.sv */
// Stage 3: cross and dot products from pairs of products.
`default_nettype none
module sis_sum import sis_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [2*CoordBits+1:0] prod_i [NumProd],
  input  wire sis_flags_t                    flags_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [2*CoordBits+2:0]      sum_o [NumSum],
  output sis_flags_t                         flags_o
);

  localparam int unsigned PW = 2 * (CoordBits + 1);
  localparam int unsigned SW = PW + 1;

  logic                 valid_q;
  logic signed [SW-1:0] sum_d [NumSum];
  logic signed [SW-1:0] sum_q [NumSum];
  sis_flags_t           flags_q;

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
    ext = $signed({p[PW-1], p});
  endfunction

  always_comb begin
    sum_d[SmD]  = ext(prod_i[PrD1xD2y]) - ext(prod_i[PrD1yD2x]);
    sum_d[SmP]  = ext(prod_i[PrWxD2y])  - ext(prod_i[PrWyD2x]);
    sum_d[SmQ]  = ext(prod_i[PrWxD1y])  - ext(prod_i[PrWyD1x]);
    sum_d[SmN2] = ext(prod_i[PrD2xD2x]) + ext(prod_i[PrD2yD2y]);
    sum_d[SmT]  = ext(prod_i[PrWxD2x])  + ext(prod_i[PrWyD2y]);
    sum_d[SmN]  = ext(prod_i[PrD1xD1x]) + ext(prod_i[PrD1yD1y]);
    sum_d[SmA]  = ext(prod_i[PrWxD1x])  + ext(prod_i[PrWyD1y]);
    sum_d[SmB]  = ext(prod_i[PrExD1x])  + ext(prod_i[PrEyD1y]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sum_q   <= sum_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

/* design/sis_decide.sv */
// Stage 4: sign and range tests, case selection and the output register.
`default_nettype none
module sis_decide import sis_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [2*CoordBits+2:0] sum_i [NumSum],
  input  wire sis_flags_t                    flags_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic                               meet_o
);

  localparam int unsigned SW = 2 * (CoordBits + 1) + 1;

  logic                 valid_q;
  logic                 meet_d, meet_q;
  logic signed [SW-1:0] d, p, q, n2, t, n, a, b;
  logic signed [SW:0]   t_n2;
  logic                 d_pos, u_p, u_q, pt_on, col_hit;

  always_comb begin
    d  = sum_i[SmD];
    p  = sum_i[SmP];
    q  = sum_i[SmQ];
    n2 = sum_i[SmN2];
    t  = sum_i[SmT];
    n  = sum_i[SmN];
    a  = sum_i[SmA];
    b  = sum_i[SmB];
    // point-on-segment test uses -t, so check -n2 <= t <= 0
    t_n2 = $signed({t[SW-1], t}) + $signed({n2[SW-1], n2});

    d_pos = !d[SW-1];
    u_p   = d_pos ? (!p[SW-1] && (p <= d)) : ((p[SW-1] || p == '0) && (p >= d));
    u_q   = d_pos ? (!q[SW-1] && (q <= d)) : ((q[SW-1] || q == '0) && (q >= d));
    pt_on = (t[SW-1] || t == '0) && !t_n2[SW];
    col_hit = (!a[SW-1] && (a <= n)) || (!b[SW-1] && (b <= n)) ||
              (a[SW-1] && (b > n)) || (b[SW-1] && (a > n));

    priority if (d != '0) begin
      meet_d = u_p && u_q;
    end else if (p != '0) begin
      meet_d = 1'b0;
    end else if (flags_i.d1_zero) begin
      meet_d = flags_i.d2_zero ? flags_i.w_zero : pt_on;
    end else if (q != '0) begin
      meet_d = 1'b0;
    end else begin
      meet_d = col_hit;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      meet_q <= meet_d;
    end
  end

  assign valid_o = valid_q;
  assign meet_o  = meet_q;

endmodule
`default_nettype wire

/* design/segment_intersection_test_top.sv */
// Top level of the closed segment intersection test pipeline.
`default_nettype none
// Takes one pair of closed segments per word and returns one word that tells whether they
// share a point. Exact integer arithmetic throughout, no division. The pipeline has four
// register stages (differences, products, cross/dot sums, decision with output register); a new
// pair is accepted every cycle while the output side is not stalled;
// each stage holds its word while the stage after it is full, so a stalled output fills the
// empty stages before the input side backs up. No state survives between words.
module segment_intersection_test_top import sis_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] first_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] first_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_end_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              segments_meet_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic                 diff_valid, diff_ready;
  logic signed [DW-1:0] diff [NumDiff];
  sis_flags_t           diff_flags;
  logic                 prod_valid, prod_ready;
  logic signed [PW-1:0] prod [NumProd];
  sis_flags_t           prod_flags;
  logic                 sum_valid, sum_ready;
  logic signed [SW-1:0] sum [NumSum];
  sis_flags_t           sum_flags;

  sis_diff #(.CoordBits(COORD_BITS)) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ax1_i   (first_start_x_i),
    .ay1_i   (first_start_y_i),
    .bx1_i   (first_end_x_i),
    .by1_i   (first_end_y_i),
    .ax2_i   (second_start_x_i),
    .ay2_i   (second_start_y_i),
    .bx2_i   (second_end_x_i),
    .by2_i   (second_end_y_i),
    .valid_o (diff_valid),
    .ready_i (diff_ready),
    .diff_o  (diff),
    .flags_o (diff_flags)
  );

  sis_prod #(.CoordBits(COORD_BITS)) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .ready_o (diff_ready),
    .diff_i  (diff),
    .flags_i (diff_flags),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod),
    .flags_o (prod_flags)
  );

  sis_sum #(.CoordBits(COORD_BITS)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .prod_i  (prod),
    .flags_i (prod_flags),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .sum_o   (sum),
    .flags_o (sum_flags)
  );

  sis_decide #(.CoordBits(COORD_BITS)) u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .sum_i   (sum),
    .flags_i (sum_flags),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .meet_o  (segments_meet_o)
  );

  // empty output register means every stage can move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // an accepted word always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> diff_valid)
    else $error("accepted word lost at first stage");

  // a point second segment forces both crosses with d2 to zero
  a_point_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid && sum_flags.d2_zero |-> (sum[SmD] == '0) && (sum[SmP] == '0))
    else $error("cross products nonzero for point segment");

  // squared lengths never negative
  a_norm_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid |-> !sum[SmN][SW-1] && !sum[SmN2][SW-1])
    else $error("negative squared length");

endmodule
`default_nettype wire

/* tb/segment_intersection_test_top_tb.sv */
// Self-checking testbench for the closed segment intersection test pipeline.
`timescale 1ns / 100ps

module segment_intersection_test_top_tb;
  import sis_pkg::*;

  localparam int CB = CoordBitsDef;
  localparam int CMin = -(2 ** (CB - 1));
  localparam int CMax = 2 ** (CB - 1) - 1;
  localparam int PipeLatency = 4;
  localparam int HoldCycles = 64;
  localparam int ItemsPerPhase = 230;
  localparam int NumPhases = 5;
  localparam int MaxPrinted = 20;

  // coordinate slots of one word
  localparam int IdxS1x = 0;
  localparam int IdxS1y = 1;
  localparam int IdxE1x = 2;
  localparam int IdxE1y = 3;
  localparam int IdxS2x = 4;
  localparam int IdxS2y = 5;
  localparam int IdxE2x = 6;
  localparam int IdxE2y = 7;

  typedef logic [7:0][CB-1:0] seg_pair_t;

  typedef struct packed {
    int  s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    bit  known;
    bit  meet;
  } dir_row_t;

  localparam int NumDirected = 24;
  localparam dir_row_t DirTable [NumDirected] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1},
    '{0, 0, 0, 0, 1, 0, 1, 0, 1, 0},
    '{CMin, CMin, CMax, CMax, CMin, CMax, CMax, CMin, 0, 0},
    '{0, 0, 10, 0, 0, 5, 10, 5, 1, 0},
    '{0, 0, 10, 0, 5, 0, 15, 0, 0, 0},
    '{0, 0, 10, 0, 11, 0, 20, 0, 0, 0},
    '{0, 0, 10, 0, -5, 0, 15, 0, 0, 0},
    '{0, 0, 10, 0, 15, 0, -5, 0, 0, 0},
    '{0, 0, 10, 0, 10, 0, 20, 0, 1, 1},
    '{5, 5, 5, 5, 0, 0, 10, 10, 0, 0},
    '{20, 20, 20, 20, 0, 0, 10, 10, 0, 0},
    '{5, 6, 5, 6, 0, 0, 10, 10, 0, 0},
    '{0, 0, 10, 10, 3, 3, 3, 3, 0, 0},
    '{0, 0, 10, 10, 3, 4, 3, 4, 0, 0},
    '{0, 0, 10, 0, 5, 0, 5, 10, 0, 0},
    '{0, 0, 10, 0, 5, 1, 5, 10, 0, 0},
    '{CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, 1, 1},
    '{CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin, 1, 1},
    '{CMin, CMin, CMax, CMin, CMin, CMax, CMax, CMax, 1, 0},
    '{CMin, 0, CMax, 0, CMax, 0, CMin, 0, 1, 1},
    '{CMin, 0, CMax, 0, 0, CMin, 0, CMax, 0, 0},
    '{10, 0, 0, 0, 5, 0, 15, 0, 0, 0},
    '{21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, 0, 0},
    '{-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845, 0, 0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CB-1:0] first_start_x_i = '0;
  logic signed [CB-1:0] first_start_y_i = '0;
  logic signed [CB-1:0] first_end_x_i = '0;
  logic signed [CB-1:0] first_end_y_i = '0;
  logic signed [CB-1:0] second_start_x_i = '0;
  logic signed [CB-1:0] second_start_y_i = '0;
  logic signed [CB-1:0] second_end_x_i = '0;
  logic signed [CB-1:0] second_end_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic segments_meet_o;

  bit meet_expected [$];
  int mismatch_count = 0;
  int result_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_request = 1'b0;

  segment_intersection_test_top #(
    .COORD_BITS(CB)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_start_x_i (first_start_x_i),
    .first_start_y_i (first_start_y_i),
    .first_end_x_i   (first_end_x_i),
    .first_end_y_i   (first_end_y_i),
    .second_start_x_i(second_start_x_i),
    .second_start_y_i(second_start_y_i),
    .second_end_x_i  (second_end_x_i),
    .second_end_y_i  (second_end_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .segments_meet_o (segments_meet_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint sext(logic [CB-1:0] v);
    return longint'($signed(v));
  endfunction

  // 0 <= num/den <= 1, den nonzero
  function automatic bit in_unit(longint num, longint den);
    if (den > 0) begin
      return num >= 0 && num <= den;
    end
    return num <= 0 && num >= den;
  endfunction

  function automatic bit predict_meet(seg_pair_t p);
    longint s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    longint d1x, d1y, d2x, d2y, wx, wy;
    longint den, p_cr, q_cr, n1, n2, t, a, b;
    s1x = sext(p[IdxS1x]);
    s1y = sext(p[IdxS1y]);
    e1x = sext(p[IdxE1x]);
    e1y = sext(p[IdxE1y]);
    s2x = sext(p[IdxS2x]);
    s2y = sext(p[IdxS2y]);
    e2x = sext(p[IdxE2x]);
    e2y = sext(p[IdxE2y]);
    d1x = e1x - s1x;
    d1y = e1y - s1y;
    d2x = e2x - s2x;
    d2y = e2y - s2y;
    wx = s2x - s1x;
    wy = s2y - s1y;
    den = d1x * d2y - d1y * d2x;
    p_cr = wx * d2y - wy * d2x;
    q_cr = wx * d1y - wy * d1x;
    if (den != 0) begin
      return in_unit(p_cr, den) && in_unit(q_cr, den);
    end
    if (p_cr != 0) begin
      return 1'b0;
    end
    if (d1x == 0 && d1y == 0) begin
      if (d2x == 0 && d2y == 0) begin
        return s1x == s2x && s1y == s2y;
      end
      n2 = d2x * d2x + d2y * d2y;
      t = (s1x - s2x) * d2x + (s1y - s2y) * d2y;
      return t >= 0 && t <= n2;
    end
    if (q_cr != 0) begin
      return 1'b0;
    end
    n1 = d1x * d1x + d1y * d1y;
    a = wx * d1x + wy * d1y;
    b = (e2x - s1x) * d1x + (e2y - s1y) * d1y;
    return (a >= 0 && a <= n1) || (b >= 0 && b <= n1) ||
           (a < 0 && b > n1) || (b < 0 && a > n1);
  endfunction

  function automatic logic [CB-1:0] small_coord(int span);
    return CB'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [CB-1:0] extreme_coord();
    case ($urandom_range(6))
      0: return CB'(CMin);
      1: return CB'(CMin + 1);
      2: return CB'(-1);
      3: return CB'(0);
      4: return CB'(1);
      5: return CB'(CMax - 1);
      default: return CB'(CMax);
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int bx, by, dx, dy, t, src, dst;
    p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0, 1, 2: begin
      end
      3, 4: begin
        for (int k = 0; k < 8; k++) p[k] = small_coord(4);
      end
      5, 6: begin
        // all four endpoints on one line
        bx = int'($urandom_range(20000)) - 10000;
        by = int'($urandom_range(20000)) - 10000;
        dx = int'($urandom_range(100)) - 50;
        dy = int'($urandom_range(100)) - 50;
        for (int k = 0; k < 4; k++) begin
          t = int'($urandom_range(40)) - 20;
          p[2 * k] = CB'(bx + t * dx);
          p[2 * k + 1] = CB'(by + t * dy);
        end
      end
      7: begin
        for (int k = 0; k < 8; k++) p[k] = small_coord(6);
        if ($urandom_range(3) == 0) begin
          p[IdxS2x] = p[IdxS1x];
          p[IdxS2y] = p[IdxS1y];
        end
        if ($urandom_range(1)) begin
          p[IdxE1x] = p[IdxS1x];
          p[IdxE1y] = p[IdxS1y];
        end
        if ($urandom_range(1)) begin
          p[IdxE2x] = p[IdxS2x];
          p[IdxE2y] = p[IdxS2y];
        end
      end
      8: begin
        src = $urandom_range(1);
        dst = 2 + $urandom_range(1);
        p[2 * dst] = p[2 * src];
        p[2 * dst + 1] = p[2 * src + 1];
      end
      default: begin
        for (int k = 0; k < 8; k++) p[k] = extreme_coord();
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic send_pair(seg_pair_t p, bit known, bit meet);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    first_start_x_i  <= p[IdxS1x];
    first_start_y_i  <= p[IdxS1y];
    first_end_x_i    <= p[IdxE1x];
    first_end_y_i    <= p[IdxE1y];
    second_start_x_i <= p[IdxS2x];
    second_start_y_i <= p[IdxS2y];
    second_end_x_i   <= p[IdxE2x];
    second_end_y_i   <= p[IdxE2y];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    meet_expected.push_back(known ? meet : predict_meet(p));
  endtask

  // output side: random stalls, or one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= int'($urandom_range(99)) >= sink_stall_pct;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    bit exp_meet;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (meet_expected.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing expected", result_count));
      end else begin
        exp_meet = meet_expected.pop_front();
        if (segments_meet_o !== exp_meet) begin
          report_mismatch($sformatf("result word %0d: segments_meet %0b, expected %0b",
                                    result_count, segments_meet_o, exp_meet));
        end
      end
      result_count++;
    end
  end

  initial begin
    #1_000_000;
    $display("segment_intersection_test_top test failed");
    $finish;
  end

  initial begin
    seg_pair_t p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTable[r]) begin
      p[IdxS1x] = CB'(DirTable[r].s1x);
      p[IdxS1y] = CB'(DirTable[r].s1y);
      p[IdxE1x] = CB'(DirTable[r].e1x);
      p[IdxE1y] = CB'(DirTable[r].e1y);
      p[IdxS2x] = CB'(DirTable[r].s2x);
      p[IdxS2y] = CB'(DirTable[r].s2y);
      p[IdxE2x] = CB'(DirTable[r].e2x);
      p[IdxE2y] = CB'(DirTable[r].e2y);
      send_pair(p, DirTable[r].known, DirTable[r].meet);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
        3: begin src_idle_pct = 25; sink_stall_pct = 25; end
        default: begin
          // long output hold-off while words keep coming
          src_idle_pct = 0;
          sink_stall_pct = 10;
          hold_request = 1'b1;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) send_pair(random_pair(), 1'b0, 1'b0);
    end
    in_valid_i <= 1'b0;
    sink_stall_pct = 0;

    while (meet_expected.size() != 0) @(posedge clk_i);
    repeat (2 * PipeLatency) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("segment_intersection_test_top test passed");
    end else begin
      $display("segment_intersection_test_top test failed");
    end
    $finish;
  end

endmodule
